>>> design/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

  // hue geometry
  localparam int unsigned HueSector = 60;
  localparam int unsigned HueFull   = 360;
  localparam int unsigned FullScale = 255;

  // denominator of the secondary channel level
  localparam int unsigned DenSecond = FullScale * HueSector;

  // reciprocal multipliers, each followed by one correction step
  localparam int unsigned RecipZero   = 257;
  localparam int unsigned ShiftZero   = 16;
  localparam int unsigned RecipSecond = 274;
  localparam int unsigned ShiftSecond = 22;

  // field widths
  localparam int unsigned HueW   = 9;
  localparam int unsigned LevelW = 8;
  localparam int unsigned SecW   = 3;
  localparam int unsigned DistW  = 6;
  localparam int unsigned SdW    = 14;
  localparam int unsigned NzW    = 16;
  localparam int unsigned NxW    = 22;

  // stream widths
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 48;

  // hue sextants
  localparam logic [SecW-1:0] SecRedYellow   = 3'd0;
  localparam logic [SecW-1:0] SecYellowGreen = 3'd1;
  localparam logic [SecW-1:0] SecGreenCyan   = 3'd2;
  localparam logic [SecW-1:0] SecCyanBlue    = 3'd3;
  localparam logic [SecW-1:0] SecBlueMagenta = 3'd4;
  localparam logic [SecW-1:0] SecMagentaRed  = 3'd5;

  // channel selectors
  localparam logic [1:0] ChanRed   = 2'd0;
  localparam logic [1:0] ChanGreen = 2'd1;
  localparam logic [1:0] ChanBlue  = 2'd2;

  // what a channel carries within a sextant
  typedef enum logic [1:0] {
    KIND_CHROMA,
    KIND_SECOND,
    KIND_ZERO
  } kind_e;

  function automatic kind_e kind_of(logic [SecW-1:0] sector, logic [1:0] chan);
    kind_e k;
    k = KIND_ZERO;
    case (sector)
      SecRedYellow: begin
        k = (chan == ChanRed) ? KIND_CHROMA : (chan == ChanGreen) ? KIND_SECOND : KIND_ZERO;
      end
      SecYellowGreen: begin
        k = (chan == ChanRed) ? KIND_SECOND : (chan == ChanGreen) ? KIND_CHROMA : KIND_ZERO;
      end
      SecGreenCyan: begin
        k = (chan == ChanRed) ? KIND_ZERO : (chan == ChanGreen) ? KIND_CHROMA : KIND_SECOND;
      end
      SecCyanBlue: begin
        k = (chan == ChanRed) ? KIND_ZERO : (chan == ChanGreen) ? KIND_SECOND : KIND_CHROMA;
      end
      SecBlueMagenta: begin
        k = (chan == ChanRed) ? KIND_SECOND : (chan == ChanGreen) ? KIND_ZERO : KIND_CHROMA;
      end
      default: begin
        k = (chan == ChanRed) ? KIND_CHROMA : (chan == ChanGreen) ? KIND_ZERO : KIND_SECOND;
      end
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> design/hsv_to_rgb_converter_core.sv
// hsv to rgb converter core
//
// one hsv color in on the slave stream, one rgb result out on the master stream
//   s_axis_tdata : hue in degrees [8:0], saturation [16:9], brightness [24:17]
//   m_axis_tdata : red [7:0], green [15:8], blue [23:16], packed rgb word [47:24]
// a hue of 360..511 is wrapped by 360 before use
//
// seven register stages: hue wrap, sextant search, two multiply stages, two
// reciprocal-correction stages (one per divisor) and the output register
// a color passes these stage registers in order before its result shows valid
// throughput is one color per cycle while m_axis_tready stays high; every stage holds one item
//
// each stage has its own valid bit and advances when it is empty or the next
// stage advances, so bubbles close up; when the receiver stalls the pipe fills
// and s_axis_tready drops once every stage is full, nothing is dropped
// reset clears all valid bits; the pipe is ready in the first cycle after it
`default_nettype none

module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // hue_degrees [8:0], saturation [16:9], brightness [24:17], zero fill [31:25]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // red_level [7:0], green_level [15:8], blue_level [23:16], packed_color [47:24]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned NumStages = 7;
  localparam int unsigned PzW = NzW + 9;
  localparam int unsigned PxW = 30;

  logic [NumStages-1:0] vld_q, vld_d, en;

  // input fields
  logic [HueW-1:0]   in_hue;
  logic [LevelW-1:0] in_sat, in_val;
  assign in_hue = s_axis_tdata[HueW-1:0];
  assign in_sat = s_axis_tdata[HueW +: LevelW];
  assign in_val = s_axis_tdata[HueW+LevelW +: LevelW];

  // stage enables, from the output back to the input
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  // valid bits travel with the data
  always_comb begin
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: wrap hue into 0..359
  logic [HueW-1:0]   s1_hue_d, s1_hue_q;
  logic [LevelW-1:0] s1_sat_q, s1_val_q;
  assign s1_hue_d = (in_hue >= HueW'(HueFull)) ? (in_hue - HueW'(HueFull)) : in_hue;

  // stage 2: sextant and distance from the sextant pair center
  logic [SecW-1:0]   s2_sec_d, s2_sec_q;
  logic [HueW-1:0]   s2_base;
  logic [6:0]        s2_frac;
  logic [DistW-1:0]  s2_dist_d, s2_dist_q;
  logic [LevelW-1:0] s2_sat_q, s2_val_q;

  always_comb begin
    if (s1_hue_q < HueW'(HueSector))          s2_sec_d = SecRedYellow;
    else if (s1_hue_q < HueW'(2 * HueSector)) s2_sec_d = SecYellowGreen;
    else if (s1_hue_q < HueW'(3 * HueSector)) s2_sec_d = SecGreenCyan;
    else if (s1_hue_q < HueW'(4 * HueSector)) s2_sec_d = SecCyanBlue;
    else if (s1_hue_q < HueW'(5 * HueSector)) s2_sec_d = SecBlueMagenta;
    else                                      s2_sec_d = SecMagentaRed;

    if (s1_hue_q < HueW'(2 * HueSector))      s2_base = '0;
    else if (s1_hue_q < HueW'(4 * HueSector)) s2_base = HueW'(2 * HueSector);
    else                                      s2_base = HueW'(4 * HueSector);

    s2_frac = 7'(s1_hue_q - s2_base);
    s2_dist_d = (s2_frac >= 7'(HueSector)) ? DistW'(s2_frac - 7'(HueSector))
                                           : DistW'(7'(HueSector) - s2_frac);
  end

  // stage 3: saturation times distance, zero-channel numerator
  logic [SdW-1:0]    s3_sd_d, s3_sd_q;
  logic [NzW-1:0]    s3_nz_d, s3_nz_q;
  logic [SecW-1:0]   s3_sec_q;
  logic [LevelW-1:0] s3_val_q;
  assign s3_sd_d = SdW'(s2_sat_q) * SdW'(s2_dist_q);
  assign s3_nz_d = NzW'(s2_val_q) * NzW'(LevelW'(FullScale) - s2_sat_q);

  // stage 4: secondary numerator, zero-channel quotient estimate
  logic [NxW-1:0]    s4_nx_d, s4_nx_q;
  logic [PzW-1:0]    s4_pz;
  logic [LevelW-1:0] s4_qz_d, s4_qz_q;
  logic [NzW-1:0]    s4_nz_q;
  logic [SecW-1:0]   s4_sec_q;
  logic [LevelW-1:0] s4_val_q;
  assign s4_nx_d = NxW'(s3_val_q) * NxW'(SdW'(DenSecond) - s3_sd_q);
  assign s4_pz   = PzW'(s3_nz_q) * PzW'(RecipZero);
  assign s4_qz_d = s4_pz[ShiftZero +: LevelW];

  // stage 5: secondary quotient estimate, zero-channel correction
  logic [PxW-1:0]    s5_px;
  logic [LevelW-1:0] s5_qx_d, s5_qx_q;
  logic [NzW-1:0]    s5_rz;
  logic [LevelW-1:0] s5_qz_d, s5_qz_q;
  logic [NxW-1:0]    s5_nx_q;
  logic [SecW-1:0]   s5_sec_q;
  logic [LevelW-1:0] s5_val_q;
  assign s5_px   = PxW'(s4_nx_q) * PxW'(RecipSecond);
  assign s5_qx_d = s5_px[ShiftSecond +: LevelW];
  assign s5_rz   = s4_nz_q - NzW'(NzW'(s4_qz_q) * NzW'(FullScale));
  assign s5_qz_d = (s5_rz >= NzW'(FullScale)) ? (s4_qz_q + 1'b1) : s4_qz_q;

  // stage 6: secondary correction
  logic [NxW-1:0]    s6_rx;
  logic [LevelW-1:0] s6_qx_d, s6_qx_q;
  logic [LevelW-1:0] s6_qz_q;
  logic [SecW-1:0]   s6_sec_q;
  logic [LevelW-1:0] s6_val_q;
  assign s6_rx   = s5_nx_q - NxW'(NxW'(s5_qx_q) * NxW'(DenSecond));
  assign s6_qx_d = (s6_rx >= NxW'(DenSecond)) ? (s5_qx_q + 1'b1) : s5_qx_q;

  // stage 7: route levels to channels by sextant
  logic [LevelW-1:0] s7_lvl_d [3];
  logic [LevelW-1:0] s7_lvl_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (kind_of(s6_sec_q, 2'(c)))
        KIND_CHROMA: s7_lvl_d[c] = s6_val_q;
        KIND_SECOND: s7_lvl_d[c] = s6_qx_q;
        default:     s7_lvl_d[c] = s6_qz_q;
      endcase
    end
  end

  // payload registers, moved on each stage enable
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_hue_q <= s1_hue_d;
      s1_sat_q <= in_sat;
      s1_val_q <= in_val;
    end
    if (en[1]) begin
      s2_sec_q  <= s2_sec_d;
      s2_dist_q <= s2_dist_d;
      s2_sat_q  <= s1_sat_q;
      s2_val_q  <= s1_val_q;
    end
    if (en[2]) begin
      s3_sd_q  <= s3_sd_d;
      s3_nz_q  <= s3_nz_d;
      s3_sec_q <= s2_sec_q;
      s3_val_q <= s2_val_q;
    end
    if (en[3]) begin
      s4_nx_q  <= s4_nx_d;
      s4_qz_q  <= s4_qz_d;
      s4_nz_q  <= s3_nz_q;
      s4_sec_q <= s3_sec_q;
      s4_val_q <= s3_val_q;
    end
    if (en[4]) begin
      s5_qx_q  <= s5_qx_d;
      s5_qz_q  <= s5_qz_d;
      s5_nx_q  <= s4_nx_q;
      s5_sec_q <= s4_sec_q;
      s5_val_q <= s4_val_q;
    end
    if (en[5]) begin
      s6_qx_q  <= s6_qx_d;
      s6_qz_q  <= s5_qz_q;
      s6_sec_q <= s5_sec_q;
      s6_val_q <= s5_val_q;
    end
    if (en[6]) begin
      s7_lvl_q <= s7_lvl_d;
    end
  end

  // output stream
  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {s7_lvl_q[ChanRed], s7_lvl_q[ChanGreen], s7_lvl_q[ChanBlue],
                          s7_lvl_q[ChanBlue], s7_lvl_q[ChanGreen], s7_lvl_q[ChanRed]};

  // an input transfer always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("input transfer did not enter the pipeline");

  // an empty output register means the whole pipe can advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NumStages-1] |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  // corrected quotients are ordered: zero level <= secondary level <= brightness
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (s6_qz_q <= s6_qx_q) && (s6_qx_q <= s6_val_q))
    else $error("channel level quotients out of order");

endmodule

`default_nettype wire
